// ===== design/ghsa_pkg.sv =====
`default_nettype none

package ghsa_pkg;

    localparam int MAX_SLOTS_DEF = 1024;
    localparam int HANDLE_W      = 32;
    localparam int INDEX_BITS    = 16;
    localparam int GEN_W         = 16;

    localparam logic [GEN_W-1:0] GEN_MAX  = 16'hFFFF;
    localparam logic [GEN_W-1:0] GEN_INIT = 16'd1;

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_CHECK   = 2'd2,
        KIND_REL_ALL = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [HANDLE_W-1:0]  handle;
    } req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0]  handle_out;
        logic                 ok;
    } res_t;

    typedef struct packed {
        logic                 live;
        logic [GEN_W-1:0]     gen;
    } slot_t;

    // Controller -> datapath
    typedef struct packed {
        logic latch;          // capture request
        logic pop;            // decrement free count, stack read in flight
        logic alloc_new;      // create next never-used slot and emit its handle
        logic rd_handle;      // read slot named by the request handle
        logic rd_stack;       // read slot named by popped stack entry
        logic alloc_pop;      // mark popped slot live and emit its handle
        logic free_on_match;  // free the slot if the handle matched
        logic walk_clear;     // restart release-all walk at slot zero
        logic walk_rd;        // read slot at walk index
        logic walk_ev;        // free walked slot if live, advance walk
        logic emit_fail;      // result: ok 0
        logic emit_ok;        // result: ok 1
        logic emit_check;     // result: ok = handle match
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        kind_t kind;
        logic  engine_ready;
        logic  free_nonzero;
        logic  can_create;
        logic  handle_valid;
        logic  walk_more;
    } stat_t;

    function automatic logic [GEN_W-1:0] gen_bump(input logic [GEN_W-1:0] g);
        return (g == GEN_MAX) ? GEN_INIT : g + GEN_INIT;
    endfunction

endpackage

`default_nettype wire

// ===== design/ghsa_ram.sv =====
`default_nettype none

module ghsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/ghsa_dp.sv =====
`default_nettype none

module ghsa_dp #(
    parameter int MAX_SLOTS = ghsa_pkg::MAX_SLOTS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ghsa_pkg::req_t  req,
    input  wire logic            cfg_we,
    input  wire logic            cfg_wdata,
    input  wire ghsa_pkg::cmd_t  cmd,
    output ghsa_pkg::stat_t      stat,
    output logic                 done,
    output ghsa_pkg::res_t       res
);

    import ghsa_pkg::*;

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    req_t              req_reg;
    logic              engine_ready_reg;
    logic [CNT_W-1:0]  free_count_reg,    free_count_next;
    logic [CNT_W-1:0]  created_count_reg, created_count_next;
    logic [CNT_W-1:0]  walk_idx_reg,      walk_idx_next;
    logic [IDX_W-1:0]  cur_idx_reg,       cur_idx_next;
    logic              done_reg,          done_next;
    res_t              res_reg,           res_next;

    logic              slot_we;
    logic [IDX_W-1:0]  slot_waddr;
    slot_t             slot_wdata;
    logic [IDX_W-1:0]  slot_raddr;
    slot_t             slot_rdata;

    logic              stack_we;
    logic [IDX_W-1:0]  stack_waddr;
    logic [IDX_W-1:0]  stack_raddr;
    logic [IDX_W-1:0]  stack_rdata;

    logic [CNT_W-1:0]      free_dec;
    logic [INDEX_BITS-1:0] req_idx;
    logic [GEN_W-1:0]      req_gen;
    logic                  match;
    logic                  commit_free;

    assign req_idx  = req_reg.handle[INDEX_BITS-1:0];
    assign req_gen  = req_reg.handle[HANDLE_W-1:INDEX_BITS];
    assign free_dec = free_count_reg - CNT_W'(1);
    assign match    = slot_rdata.live && (slot_rdata.gen == req_gen);

    assign commit_free = (cmd.free_on_match && match) || (cmd.walk_ev && slot_rdata.live);

    always_comb
    begin
        stat.kind         = req_reg.kind;
        stat.engine_ready = engine_ready_reg;
        stat.free_nonzero = (free_count_reg != '0);
        stat.can_create   = (32'(created_count_reg) < 32'(MAX_SLOTS));
        stat.handle_valid = (req_reg.handle != '0) &&
                            (32'(req_idx) < 32'(created_count_reg));
        stat.walk_more    = (walk_idx_reg < created_count_reg);
    end

    // Slot table read address: popped index, walk index, or request index
    always_comb
    begin
        priority if (cmd.rd_stack)
            slot_raddr = stack_rdata;
        else if (cmd.walk_rd)
            slot_raddr = walk_idx_reg[IDX_W-1:0];
        else
            slot_raddr = req_idx[IDX_W-1:0];
    end

    assign cur_idx_next = (cmd.rd_stack || cmd.walk_rd || cmd.rd_handle) ?
                          slot_raddr : cur_idx_reg;

    always_comb
    begin
        slot_we    = 1'b0;
        slot_waddr = cur_idx_reg;
        slot_wdata = '{live: 1'b0, gen: gen_bump(slot_rdata.gen)};
        priority if (cmd.alloc_new)
        begin
            slot_we    = 1'b1;
            slot_waddr = created_count_reg[IDX_W-1:0];
            slot_wdata = '{live: 1'b1, gen: GEN_INIT};
        end
        else if (cmd.alloc_pop)
        begin
            slot_we    = 1'b1;
            slot_wdata = '{live: 1'b1, gen: slot_rdata.gen};
        end
        else if (commit_free)
        begin
            slot_we = 1'b1;
        end
    end

    assign stack_we    = commit_free;
    assign stack_waddr = free_count_reg[IDX_W-1:0];
    assign stack_raddr = free_dec[IDX_W-1:0];

    always_comb
    begin
        free_count_next    = free_count_reg;
        created_count_next = created_count_reg;
        walk_idx_next      = walk_idx_reg;
        if (cmd.pop)
            free_count_next = free_dec;
        else if (commit_free)
            free_count_next = free_count_reg + CNT_W'(1);
        if (cmd.alloc_new)
            created_count_next = created_count_reg + CNT_W'(1);
        if (cmd.walk_clear)
            walk_idx_next = '0;
        else if (cmd.walk_ev)
            walk_idx_next = walk_idx_reg + CNT_W'(1);
    end

    always_comb
    begin
        done_next = cmd.emit_fail || cmd.emit_ok || cmd.emit_check ||
                    cmd.alloc_new || cmd.alloc_pop;
        res_next  = '{handle_out: '0, ok: 1'b0};
        priority if (cmd.alloc_new)
            res_next = '{handle_out: {GEN_INIT,
                                      INDEX_BITS'(created_count_reg[IDX_W-1:0])},
                         ok: 1'b1};
        else if (cmd.alloc_pop)
            res_next = '{handle_out: {slot_rdata.gen, INDEX_BITS'(cur_idx_reg)},
                         ok: 1'b1};
        else if (cmd.emit_check)
            res_next.ok = match;
        else if (cmd.emit_ok)
            res_next.ok = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            engine_ready_reg  <= 1'b0;
            free_count_reg    <= '0;
            created_count_reg <= '0;
            walk_idx_reg      <= '0;
            done_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                engine_ready_reg <= cfg_wdata;
            free_count_reg    <= free_count_next;
            created_count_reg <= created_count_next;
            walk_idx_reg      <= walk_idx_next;
            done_reg          <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            req_reg <= req;
        cur_idx_reg <= cur_idx_next;
        res_reg     <= res_next;
    end

    ghsa_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    ghsa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_SLOTS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (cur_idx_reg),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    assign done = done_reg;
    assign res  = res_reg;

    a_free_le_created: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= created_count_reg)
        else $error("free count exceeds created count");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        commit_free |-> (32'(free_count_reg) < 32'(MAX_SLOTS)))
        else $error("push onto a full free stack");

endmodule

`default_nettype wire

// ===== design/ghsa_ctrl.sv =====
`default_nettype none

module ghsa_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire ghsa_pkg::stat_t stat,
    output ghsa_pkg::cmd_t       cmd,
    output logic                 busy
);

    import ghsa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_POP_WAIT,
        S_ALLOC_EV,
        S_CHK_EV,
        S_WALK_RD,
        S_WALK_EV
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                unique case (stat.kind)
                    KIND_ALLOC:
                    begin
                        priority if (!stat.engine_ready)
                            cmd.emit_fail = 1'b1;
                        else if (stat.free_nonzero)
                        begin
                            cmd.pop    = 1'b1;
                            state_next = S_POP_WAIT;
                        end
                        else if (stat.can_create)
                            cmd.alloc_new = 1'b1;
                        else
                            cmd.emit_fail = 1'b1;
                    end
                    KIND_RELEASE, KIND_CHECK:
                    begin
                        if (stat.handle_valid)
                        begin
                            cmd.rd_handle = 1'b1;
                            state_next    = S_CHK_EV;
                        end
                        else
                            cmd.emit_fail = 1'b1;
                    end
                    KIND_REL_ALL:
                    begin
                        cmd.walk_clear = 1'b1;
                        state_next     = S_WALK_RD;
                    end
                    default:
                        cmd.emit_fail = 1'b1;
                endcase
            end
            S_POP_WAIT:
            begin
                cmd.rd_stack = 1'b1;
                state_next   = S_ALLOC_EV;
            end
            S_ALLOC_EV:
            begin
                cmd.alloc_pop = 1'b1;
                state_next    = S_IDLE;
            end
            S_CHK_EV:
            begin
                cmd.emit_check    = 1'b1;
                cmd.free_on_match = (stat.kind == KIND_RELEASE);
                state_next        = S_IDLE;
            end
            S_WALK_RD:
            begin
                if (stat.walk_more)
                begin
                    cmd.walk_rd = 1'b1;
                    state_next  = S_WALK_EV;
                end
                else
                begin
                    cmd.emit_ok = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_WALK_EV:
            begin
                cmd.walk_ev = 1'b1;
                state_next  = S_WALK_RD;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ===== design/generational_handle_slot_allocator.sv =====
`default_nettype none

// Sequence, from the accepting edge to the result: allocate of a new slot or a failing request
// passes through decode only; release or check of a valid handle adds a slot read; allocate from
// the free stack adds a stack read then a slot read, both through registered-read RAM; release-all
// does one slot read per created slot and a write-back of each live one on the single RAM port pair.
// Throughput: busy drops as done rises, so the next request is taken at the edge that ends the
// done cycle; receiver cannot stall done/res. Reset clears counters, engine_ready and the FSM.

module generational_handle_slot_allocator #(
    parameter int MAX_SLOTS = ghsa_pkg::MAX_SLOTS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    // Request transaction: taken when start is high and busy is low
    input  wire logic           start,
    input  wire ghsa_pkg::req_t req,
    output logic                busy,
    // Result transaction: valid for exactly one cycle while done is high
    output logic                done,
    output ghsa_pkg::res_t      res,
    // engine_ready register write port
    input  wire logic           cfg_we,
    input  wire logic           cfg_wdata
);

    import ghsa_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Controller sequences each request; datapath owns the slot table, the
    // free stack, the slot counters and the result register.
    ghsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Slot table entries at or above the created count are never used, so
    // they need no reset value and no clearing sweep: a new slot is
    // written as live with generation one.
    ghsa_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .res       (res)
    );

    // A result is emitted on the way back to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while controller busy");

    // Only a successful allocate hands out a nonzero handle.
    a_handle_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (res.handle_out != '0)) |-> res.ok)
        else $error("nonzero handle without ok");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

import ghsa_pkg::*;

localparam int IDX_W = $clog2(MAX_SLOTS_DEF);

class slot_map_tracker;
    logic [GEN_W-1:0]    gen_of [MAX_SLOTS_DEF];
    bit                  live_of [MAX_SLOTS_DEF];
    logic [IDX_W-1:0]    free_list [MAX_SLOTS_DEF];
    logic [IDX_W:0]      free_depth;
    logic [IDX_W:0]      created;
    bit                  ready;
    res_t                expected_results [$];
    int                  errors;

    function new();
        foreach (gen_of[i])
        begin
            gen_of[i] = GEN_INIT;
            live_of[i] = 1'b0;
            free_list[i] = '0;
        end
        free_depth = '0;
        created = '0;
        ready = 1'b0;
        errors = 0;
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    function logic [GEN_W-1:0] next_gen(input logic [GEN_W-1:0] g);
        return (g == GEN_MAX) ? GEN_INIT : g + 16'd1;
    endfunction

    function logic [HANDLE_W-1:0] make_handle(input logic [IDX_W-1:0] idx);
        return {gen_of[idx], {(INDEX_BITS-IDX_W){1'b0}}, idx};
    endfunction

    function bit handle_holds(input logic [HANDLE_W-1:0] h);
        if (h == '0)
            return 1'b0;
        if (h[INDEX_BITS-1:0] >= created)
            return 1'b0;
        return live_of[h[IDX_W-1:0]] && (gen_of[h[IDX_W-1:0]] == h[HANDLE_W-1:INDEX_BITS]);
    endfunction

    function void free_slot(input logic [IDX_W-1:0] idx);
        if (idx >= created || !live_of[idx])
            return;
        live_of[idx] = 1'b0;
        gen_of[idx] = next_gen(gen_of[idx]);
        if (free_depth < MAX_SLOTS_DEF)
        begin
            free_list[free_depth] = idx;
            free_depth = free_depth + 1'b1;
        end
    endfunction

    function void take_request(input req_t r);
        res_t             e;
        logic [IDX_W-1:0] idx;
        bit               got;
        e = '0;
        idx = '0;
        got = 1'b0;
        case (r.kind)
            KIND_ALLOC:
            begin
                if (ready)
                begin
                    if (free_depth != 0)
                    begin
                        free_depth = free_depth - 1'b1;
                        idx = free_list[free_depth];
                        got = 1'b1;
                    end
                    else if (created < MAX_SLOTS_DEF)
                    begin
                        idx = created[IDX_W-1:0];
                        created = created + 1'b1;
                        got = 1'b1;
                    end
                    if (got)
                    begin
                        live_of[idx] = 1'b1;
                        e.handle_out = make_handle(idx);
                        e.ok = 1'b1;
                    end
                end
            end
            KIND_RELEASE:
            begin
                if (handle_holds(r.handle))
                begin
                    free_slot(r.handle[IDX_W-1:0]);
                    e.ok = 1'b1;
                end
            end
            KIND_CHECK:
                e.ok = handle_holds(r.handle);
            default:
            begin
                for (int i = 0; i < created; i++)
                    free_slot(IDX_W'(i));
                e.ok = 1'b1;
            end
        endcase
        expected_results.insert(expected_results.size(), e);
    endfunction

    function logic [HANDLE_W-1:0] live_handle();
        int first;
        int idx;
        if (created == 0)
            return '0;
        first = $urandom_range(0, created - 1);
        for (int k = 0; k < created; k++)
        begin
            idx = (first + k) % created;
            if (live_of[idx])
                return make_handle(IDX_W'(idx));
        end
        return '0;
    endfunction

    function logic [HANDLE_W-1:0] stale_handle();
        logic [IDX_W-1:0] idx;
        logic [GEN_W-1:0] off;
        logic [GEN_W-1:0] g;
        if (created == 0)
            return $urandom;
        idx = $urandom_range(0, created - 1);
        off = $urandom_range(1, 3);
        if ($urandom_range(0, 1))
            off = 16'd0 - off;
        if (!live_of[idx] && $urandom_range(0, 1))
            off = '0;
        g = gen_of[idx] + off;
        return {g, {(INDEX_BITS-IDX_W){1'b0}}, idx};
    endfunction

    task report(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        errors++;
    endtask

    task match_result(input res_t got);
        res_t want;
        if (expected_results.size() == 0)
        begin
            report($sformatf("unexpected result handle_out %h ok %b", got.handle_out, got.ok));
            return;
        end
        want = expected_results.pop_front();
        if (got.handle_out !== want.handle_out)
            report($sformatf("handle_out %h, expected %h", got.handle_out, want.handle_out));
        if (got.ok !== want.ok)
            report($sformatf("ok %b, expected %b", got.ok, want.ok));
    endtask
endclass

module testbench;

    // Longest legal stretch without a transaction is a release-all over a full
    // table; allow several times that.
    localparam int QUIET_LIMIT = 12000;
    localparam int RANDOM_ITEMS = 680;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic done;
    res_t res;
    logic cfg_we;
    logic cfg_wdata;

    slot_map_tracker tracker;
    bit              idle_on;
    int              quiet_cycles = 0;
    int              step_no;
    int              pick;

    generational_handle_slot_allocator uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .req(req),
        .busy(busy),
        .done(done),
        .res(res),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Compare every result transaction against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.match_result(res);
    end

    // Abort when neither side moves a transaction for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Mostly back-to-back, sometimes a short gap, rarely a long hole; no gap while idle_on is clear.
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 60);
    endfunction

    // Present one request transaction and hold it until the block takes it.
    // Leave start high on return so the next request can follow without a gap.
    task automatic send(input kind_t k, input logic [HANDLE_W-1:0] h);
        int   gap;
        req_t item;
        gap = pick_gap();
        item = '{kind: k, handle: h};
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.take_request(item);
    endtask

    // Drop start and wait until every predicted result has come back.
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    // Write engine_ready while the block is idle; the write lands on the next edge.
    task automatic write_ready(input bit value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        tracker.ready = value;
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        tracker = new();
        rst_n <= 1'b0;
        start <= 1'b0;
        req <= '0;
        cfg_we <= 1'b0;
        cfg_wdata <= 1'b0;
        idle_on = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: engine not ready out of reset, so allocate must fail while
        // the other kinds still answer.
        send(KIND_ALLOC, 32'hFFFF_FFFF);
        send(KIND_CHECK, 32'h0000_0000);
        send(KIND_RELEASE, 32'h0000_0000);
        send(KIND_REL_ALL, 32'hFFFF_FFFF);
        send(KIND_CHECK, 32'hFFFF_FFFF);
        write_ready(1'b1);
        send(KIND_ALLOC, 32'h0000_0000);
        send(KIND_ALLOC, 32'hFFFF_FFFF);
        send(KIND_CHECK, 32'h0001_0000);
        // generation zero never matches
        send(KIND_CHECK, 32'h0000_0001);
        // index not created yet
        send(KIND_CHECK, 32'h0001_0002);
        send(KIND_RELEASE, 32'h0001_0002);
        send(KIND_RELEASE, 32'h0001_0001);
        // same handle again is stale now
        send(KIND_RELEASE, 32'h0001_0001);
        send(KIND_CHECK, 32'h0001_0001);
        // pop the freed slot back with its bumped generation
        send(KIND_ALLOC, 32'h0000_0000);
        send(KIND_CHECK, 32'h0002_0001);
        send(KIND_RELEASE, 32'h0001_FFFF);
        write_ready(1'b0);
        send(KIND_ALLOC, 32'h0000_0000);
        send(KIND_CHECK, 32'h0002_0001);
        send(KIND_RELEASE, 32'h0001_0000);
        send(KIND_REL_ALL, 32'h0000_0000);
        send(KIND_CHECK, 32'h0002_0001);
        write_ready(1'b1);
        // release-all with nothing live
        send(KIND_REL_ALL, 32'h0000_0000);

        // Random mix: mostly well-formed handles, some stale, some noise.
        for (step_no = 0; step_no < RANDOM_ITEMS; step_no++)
        begin
            if (step_no % 50 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (step_no % 100 == 99)
                write_ready($urandom_range(0, 99) < 75);
            else if ($urandom_range(0, 49) == 0)
                drain();
            pick = $urandom_range(0, 99);
            if (pick < 35)
                send(KIND_ALLOC, $urandom);
            else if (pick < 55)
                send(KIND_RELEASE, tracker.live_handle());
            else if (pick < 63)
                send(KIND_RELEASE, tracker.stale_handle());
            else if (pick < 68)
                send(KIND_RELEASE, $urandom);
            else if (pick < 80)
                send(KIND_CHECK, tracker.live_handle());
            else if (pick < 88)
                send(KIND_CHECK, tracker.stale_handle());
            else if (pick < 95)
                send(KIND_CHECK, $urandom);
            else
                send(KIND_REL_ALL, $urandom);
        end

        // Wait out the tail, then give the verdict.
        drain();
        repeat (20) @(posedge clk);
        if (tracker.pending() != 0)
            tracker.report("predicted results never arrived");
        if (tracker.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/ghsa_pkg.sv
design/ghsa_ram.sv
design/ghsa_dp.sv
design/ghsa_ctrl.sv
design/generational_handle_slot_allocator.sv
test/testbench.sv
